@@ rtl/buddy_page_allocator_unit_defines.svh @@
// ============================================================================
// Buddy page allocator assertion macros
// Shared concurrent assertion forms; they compile away when NO_ASSERTIONS is
// defined.
// ============================================================================
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy page allocator: assertion failed");
// Next-cycle implication.
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy page allocator: assertion failed");
`else
`define BPA_ASSERT_NOW(label, clk, rst, ante, cons)
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Buddy page allocator package
// Command and status codes, register indexes and shared record types.
// ============================================================================
package bpa_pkg;

   localparam int POOL_PAGES_DEF = 4096;
   localparam int TOP_ORDER_DEF  = 10;
   localparam int PAGE_SHIFT_DEF = 12;

   // Order counters must reach one past the largest order (16).
   localparam int ORD_W = 5;

   typedef enum logic [2:0] {
      CMD_SEED        = 3'd0,
      CMD_ALLOC_ORDER = 3'd1,
      CMD_ALLOC_PAGES = 3'd2,
      CMD_ALLOC_BYTES = 3'd3,
      CMD_FREE        = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_NULL         = 4'd1,
      ST_NO_MEMORY    = 4'd2,
      ST_TOO_LARGE    = 4'd3,
      ST_BAD_ORDER    = 4'd4,
      ST_MISALIGNED   = 4'd5,
      ST_OUTSIDE      = 4'd6,
      ST_DOUBLE_FREE  = 4'd7,
      ST_ORDER_MISAL  = 4'd8,
      ST_BAD_REGION   = 4'd9,
      ST_LIST_MISSING = 4'd10
   } status_type;

   localparam logic CSR_REGION_BASE_PAGE = 1'b0;
   localparam logic CSR_REGION_PAGES     = 1'b1;

   // Per-page bookkeeping word.
   typedef struct packed {
      logic [3:0] order;
      logic       free;
   } meta_type;

   // Write strobes toward the page store.
   typedef struct packed {
      logic next_we;
      logic meta_we;
   } we_type;

endpackage

@@ rtl/bpa_store.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Buddy page allocator page store
// Per-page link and bookkeeping memories, one write port each and a shared
// read address with registered read data.
// ============================================================================
module bpa_store #(
   parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF
) (
   input  logic                                  clock,
   input  bpa_pkg::we_type                       we,
   input  logic [$clog2(POOL_PAGES+1)-1:0]       rd_addr,
   input  logic [$clog2(POOL_PAGES+1)-1:0]       next_waddr,
   input  logic [$clog2(POOL_PAGES+1)-1:0]       next_wdata,
   input  logic [$clog2(POOL_PAGES+1)-1:0]       meta_waddr,
   input  bpa_pkg::meta_type                     meta_wdata,
   output logic [$clog2(POOL_PAGES+1)-1:0]       next_rdata,
   output bpa_pkg::meta_type                     meta_rdata
);
   import bpa_pkg::*;

   localparam int PTR_W  = $clog2(POOL_PAGES + 1);
   localparam int ADDR_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;

   logic [PTR_W-1:0] next_mem [POOL_PAGES];
   meta_type         meta_mem [POOL_PAGES];

   always_ff @(posedge clock) begin
      if (we.next_we) begin
         next_mem[next_waddr[ADDR_W-1:0]] <= next_wdata;
      end
      if (we.meta_we) begin
         meta_mem[meta_waddr[ADDR_W-1:0]] <= meta_wdata;
      end
      next_rdata <= next_mem[rd_addr[ADDR_W-1:0]];
      meta_rdata <= meta_mem[rd_addr[ADDR_W-1:0]];
   end

endmodule

@@ rtl/buddy_page_allocator_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Buddy page allocator
// Binary buddy allocator over one page-aligned region with a LIFO free list
// per order, driven by a small sequencer over a shared page store.
// ============================================================================
//
//   Channel   Ports                                  Direction  Handshake
//   request   start, busy, req_*                     in         start & !busy
//   response  rsp_valid, rsp_*                       out        one-cycle strobe
//   config    csr_write_enable, csr_index, csr_*     in         write enable
//
// One transaction is worked on at a time; busy stays high until its response
// is issued. Allocation scans the orders upward for a non-empty list, pops the
// list head and splits it down to the wanted order; sized requests first step
// up through the orders until one fits. Free runs an address check and then a
// bookkeeping check, then a check pass and an apply pass over the merge levels,
// each level reading the buddy and walking its list in the single-ported link
// memory, with a closing step per pass. Seeding first sweeps the bookkeeping
// memory over all POOL_PAGES pages, then lays out the region block by block.
// Reset is synchronous and clears all lists; the memories need no clearing
// pass because nothing reads them before the first seed sweep.
// The response strobe lasts one cycle and cannot be held off.
//
module buddy_page_allocator_unit #(
   parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
   parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
   parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_order,
   input  logic [31:0] req_amount,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_block_address,
   output logic [3:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [19:0] csr_write_data
);
   import bpa_pkg::*;
`include "buddy_page_allocator_unit_defines.svh"

   localparam int PTR_W  = $clog2(POOL_PAGES + 1);
   localparam int ADDR_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int HW     = $clog2(TOP_ORDER + 1);
   localparam int XW     = PTR_W + 17;
   localparam logic [PTR_W-1:0]  NIL   = PTR_W'(POOL_PAGES);
   localparam logic [ORD_W-1:0]  TOP_O = ORD_W'(TOP_ORDER);
   localparam logic [ADDR_W-1:0] LAST  = ADDR_W'(POOL_PAGES - 1);

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_SEED_CLR = 16'h0002,
      S_SEED_ORD = 16'h0004,
      S_SIZE     = 16'h0008,
      S_FIND     = 16'h0010,
      S_POP      = 16'h0020,
      S_SPLIT    = 16'h0040,
      S_FCHK     = 16'h0080,
      S_FMETA    = 16'h0100,
      S_MTEST    = 16'h0200,
      S_MREL     = 16'h0400,
      S_WALK     = 16'h0800,
      S_WNEXT    = 16'h1000,
      S_UNLINK   = 16'h2000,
      S_MUP      = 16'h4000,
      S_MEND     = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   // List heads and region registers.
   logic [PTR_W-1:0] head_ff [TOP_ORDER+1];
   logic [PTR_W-1:0] head_in [TOP_ORDER+1];
   logic [19:0]      rbp_ff, rbp_in;
   logic [12:0]      rpages_ff, rpages_in;
   logic [PTR_W-1:0] live_pages_ff, live_pages_in;
   logic [31:0]      live_base_ff, live_base_in;
   logic [32:0]      live_end_ff, live_end_in;

   // Sequencer working registers.
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [3:0]        want_ff, want_in;
   logic [3:0]        ord0_ff, ord0_in;
   logic              apply_ff, apply_in;
   logic [PTR_W-1:0]  t_ff, t_in;
   logic [PTR_W-1:0]  b_ff, b_in;
   logic [PTR_W-1:0]  idx_ff, idx_in;
   logic [PTR_W-1:0]  rel_ff, rel_in;
   logic [PTR_W-1:0]  prev_ff, prev_in;
   logic [PTR_W-1:0]  walk_ff, walk_in;
   logic [PTR_W-1:0]  steps_ff, steps_in;
   logic [PTR_W-1:0]  off_ff, off_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [32:0]       need_ff, need_in;
   logic [31:0]       addr_ff, addr_in;

   // Response registers.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [3:0]  rsp_status_ff, rsp_status_in;

   // Page store interface.
   we_type           we;
   logic [PTR_W-1:0] rd_addr, next_waddr, next_wdata, meta_waddr, next_rdata;
   meta_type         meta_wdata, meta_rdata;

   bpa_store #(.POOL_PAGES(POOL_PAGES)) u_store (
      .clock      (clock),
      .we         (we),
      .rd_addr    (rd_addr),
      .next_waddr (next_waddr),
      .next_wdata (next_wdata),
      .meta_waddr (meta_waddr),
      .meta_wdata (meta_wdata),
      .next_rdata (next_rdata),
      .meta_rdata (meta_rdata)
   );

   // Shared datapath terms; the order-dependent ones all use the one order register.
   logic [HW-1:0]    ord_idx;
   logic [PTR_W-1:0] head_sel;
   logic [XW-1:0]    pow_x, rel_x, split_x, off_x, blk_end_x;
   logic             grow_ok, rel_out, fit_ok;
   logic [39:0]      base40, end40;
   logic             seed_bad;
   logic [31:0]      alloc_addr;
   logic [31:0]      free_off;
   logic [PTR_W-1:0] min_b;

   always_comb begin
      ord_idx   = ord_ff[HW-1:0];
      head_sel  = head_ff[ord_idx];
      pow_x     = XW'(1) << ord_ff;
      off_x     = XW'(off_ff);
      blk_end_x = off_x + pow_x;
      grow_ok   = (ord_ff < TOP_O)
                  && ((off_x & ((pow_x << 1) - XW'(1))) == '0)
                  && (off_x + (pow_x << 1) <= XW'(live_pages_ff));
      rel_x     = XW'(b_ff) ^ pow_x;
      rel_out   = rel_x >= XW'(live_pages_ff);
      split_x   = XW'(t_ff) + pow_x;
      fit_ok    = (33'(1) << ord_ff) >= need_ff;
      base40    = 40'(rbp_ff) << PAGE_SHIFT;
      end40     = (40'(rbp_ff) + 40'(rpages_ff)) << PAGE_SHIFT;
      seed_bad  = (rpages_ff == '0) || (21'(rpages_ff) > 21'(POOL_PAGES))
                  || (end40 > 40'h01_0000_0000);
      alloc_addr = live_base_ff + (32'(t_ff) << PAGE_SHIFT);
      free_off   = (addr_ff - live_base_ff) >> PAGE_SHIFT;
      min_b      = (rel_ff < b_ff) ? rel_ff : b_ff;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      rbp_in        = rbp_ff;
      rpages_in     = rpages_ff;
      live_pages_in = live_pages_ff;
      live_base_in  = live_base_ff;
      live_end_in   = live_end_ff;
      ord_in        = ord_ff;
      want_in       = want_ff;
      ord0_in       = ord0_ff;
      apply_in      = apply_ff;
      t_in          = t_ff;
      b_in          = b_ff;
      idx_in        = idx_ff;
      rel_in        = rel_ff;
      prev_in       = prev_ff;
      walk_in       = walk_ff;
      steps_in      = steps_ff;
      off_in        = off_ff;
      clr_in        = clr_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      we            = '0;
      rd_addr       = '0;
      next_waddr    = '0;
      next_wdata    = '0;
      meta_waddr    = '0;
      meta_wdata    = '0;

      // The user must issue configuration writes only while the unit is idle; the unit does not enforce it.
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REGION_BASE_PAGE: rbp_in    = csr_write_data;
            CSR_REGION_PAGES:     rpages_in = csr_write_data[12:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in = req_address;
               ord_in  = '0;
               unique case (req_command)
                  CMD_SEED: begin
                     if (seed_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_REGION;
                        rsp_addr_in   = '0;
                     end else begin
                        live_pages_in = PTR_W'(rpages_ff);
                        live_base_in  = base40[31:0];
                        live_end_in   = end40[32:0];
                        for (int k = 0; k <= TOP_ORDER; k++) head_in[k] = NIL;
                        clr_in   = '0;
                        state_in = S_SEED_CLR;
                     end
                  end
                  CMD_ALLOC_ORDER: begin
                     if (5'(req_order) > TOP_O) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_ORDER;
                        rsp_addr_in   = '0;
                     end else begin
                        want_in  = req_order;
                        ord_in   = ORD_W'(req_order);
                        state_in = S_FIND;
                     end
                  end
                  CMD_ALLOC_PAGES, CMD_ALLOC_BYTES: begin
                     if (req_amount == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NULL;
                        rsp_addr_in   = '0;
                     end else begin
                        // Byte requests are rounded up to whole pages first.
                        if (req_command == CMD_ALLOC_PAGES) begin
                           need_in = 33'(req_amount);
                        end else begin
                           need_in = 33'((req_amount - 32'd1) >> PAGE_SHIFT) + 33'd1;
                        end
                        state_in = S_SIZE;
                     end
                  end
                  CMD_FREE: state_in = S_FCHK;
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NULL;
                     rsp_addr_in   = '0;
                  end
               endcase
            end
         end

         S_SEED_CLR: begin
            we.meta_we = 1'b1;
            meta_waddr = PTR_W'(clr_ff);
            meta_wdata = '{order: 4'd0, free: 1'b1};
            if (clr_ff == LAST) begin
               off_in   = '0;
               ord_in   = '0;
               state_in = S_SEED_ORD;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end

         S_SEED_ORD: begin
            if (grow_ok) begin
               ord_in = ord_ff + ORD_W'(1);
            end else begin
               we.meta_we = 1'b1;
               meta_waddr = off_ff;
               meta_wdata = '{order: ord_ff[3:0], free: 1'b1};
               we.next_we = 1'b1;
               next_waddr = off_ff;
               next_wdata = head_sel;
               head_in[ord_idx] = off_ff;
               off_in = PTR_W'(blk_end_x);
               ord_in = '0;
               if (blk_end_x >= XW'(live_pages_ff)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_addr_in   = '0;
                  state_in      = S_IDLE;
               end
            end
         end

         S_SIZE: begin
            if (ord_ff > TOP_O) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_TOO_LARGE;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if (fit_ok) begin
               want_in  = ord_ff[3:0];
               state_in = S_FIND;
            end else begin
               ord_in = ord_ff + ORD_W'(1);
            end
         end

         S_FIND: begin
            if (ord_ff > TOP_O) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_MEMORY;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if (head_sel >= NIL) begin
               ord_in = ord_ff + ORD_W'(1);
            end else begin
               t_in       = head_sel;
               rd_addr    = head_sel;
               we.meta_we = 1'b1;
               meta_waddr = head_sel;
               meta_wdata = '{order: want_ff, free: 1'b0};
               state_in   = S_POP;
            end
         end

         S_POP: begin
            head_in[ord_idx] = next_rdata;
            if (ord_ff > ORD_W'(want_ff)) begin
               ord_in   = ord_ff - ORD_W'(1);
               state_in = S_SPLIT;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = alloc_addr;
               state_in      = S_IDLE;
            end
         end

         S_SPLIT: begin
            // Upper half of the block at this level goes onto its list.
            if (split_x < XW'(POOL_PAGES)) begin
               we.meta_we = 1'b1;
               meta_waddr = PTR_W'(split_x);
               meta_wdata = '{order: ord_ff[3:0], free: 1'b1};
               we.next_we = 1'b1;
               next_waddr = PTR_W'(split_x);
               next_wdata = head_sel;
               head_in[ord_idx] = PTR_W'(split_x);
            end
            if (ord_ff > ORD_W'(want_ff)) begin
               ord_in = ord_ff - ORD_W'(1);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = alloc_addr;
               state_in      = S_IDLE;
            end
         end

         S_FCHK: begin
            priority if (addr_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NULL;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if (addr_ff[PAGE_SHIFT-1:0] != '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISALIGNED;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if ((addr_ff < live_base_ff) || (33'(addr_ff) >= live_end_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OUTSIDE;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in   = PTR_W'(free_off);
               rd_addr  = PTR_W'(free_off);
               state_in = S_FMETA;
            end
         end

         S_FMETA: begin
            priority if (meta_rdata.free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DOUBLE_FREE;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if (ORD_W'(meta_rdata.order) > TOP_O) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_BAD_ORDER;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if ((XW'(idx_ff) & ((XW'(1) << meta_rdata.order) - XW'(1))) != '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ORDER_MISAL;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else begin
               ord_in   = ORD_W'(meta_rdata.order);
               ord0_in  = meta_rdata.order;
               b_in     = idx_ff;
               apply_in = 1'b0;
               state_in = S_MTEST;
            end
         end

         S_MTEST: begin
            if ((ord_ff >= TOP_O) || rel_out) begin
               state_in = S_MEND;
            end else begin
               rel_in   = PTR_W'(rel_x);
               rd_addr  = PTR_W'(rel_x);
               state_in = S_MREL;
            end
         end

         S_MREL: begin
            if (!meta_rdata.free || (ORD_W'(meta_rdata.order) != ord_ff)) begin
               state_in = S_MEND;
            end else begin
               prev_in  = NIL;
               walk_in  = head_sel;
               steps_in = '0;
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            priority if ((walk_ff >= NIL) || (steps_ff >= NIL)) begin
               // The buddy looked free but is not on its list.
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LIST_MISSING;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if (walk_ff == rel_ff) begin
               if (apply_ff) begin
                  rd_addr  = walk_ff;
                  state_in = S_UNLINK;
               end else begin
                  state_in = S_MUP;
               end
            end else begin
               rd_addr  = walk_ff;
               state_in = S_WNEXT;
            end
         end

         S_WNEXT: begin
            prev_in  = walk_ff;
            walk_in  = next_rdata;
            steps_in = steps_ff + PTR_W'(1);
            state_in = S_WALK;
         end

         S_UNLINK: begin
            if (prev_ff >= NIL) begin
               head_in[ord_idx] = next_rdata;
            end else begin
               we.next_we = 1'b1;
               next_waddr = prev_ff;
               next_wdata = next_rdata;
            end
            we.meta_we = 1'b1;
            meta_waddr = rel_ff;
            meta_wdata = '{order: ord_ff[3:0], free: 1'b0};
            state_in   = S_MUP;
         end

         S_MUP: begin
            b_in   = min_b;
            ord_in = ord_ff + ORD_W'(1);
            if (apply_ff) begin
               we.meta_we = 1'b1;
               meta_waddr = min_b;
               meta_wdata = '{order: 4'(ord_ff + ORD_W'(1)), free: 1'b1};
            end
            state_in = S_MTEST;
         end

         S_MEND: begin
            if (!apply_ff) begin
               // Check pass found nothing wrong: repeat the walk and write.
               apply_in   = 1'b1;
               b_in       = idx_ff;
               ord_in     = ORD_W'(ord0_ff);
               we.meta_we = 1'b1;
               meta_waddr = idx_ff;
               meta_wdata = '{order: ord0_ff, free: 1'b1};
               state_in   = S_MTEST;
            end else begin
               we.next_we = 1'b1;
               next_waddr = b_ff;
               next_wdata = head_sel;
               head_in[ord_idx] = b_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         rbp_ff        <= '0;
         rpages_ff     <= '0;
         live_pages_ff <= '0;
         live_base_ff  <= '0;
         live_end_ff   <= '0;
         for (int k = 0; k <= TOP_ORDER; k++) head_ff[k] <= NIL;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rbp_ff        <= rbp_in;
         rpages_ff     <= rpages_in;
         live_pages_ff <= live_pages_in;
         live_base_ff  <= live_base_in;
         live_end_ff   <= live_end_in;
         head_ff       <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff        <= ord_in;
      want_ff       <= want_in;
      ord0_ff       <= ord0_in;
      apply_ff      <= apply_in;
      t_ff          <= t_in;
      b_ff          <= b_in;
      idx_ff        <= idx_in;
      rel_ff        <= rel_in;
      prev_ff       <= prev_in;
      walk_ff       <= walk_in;
      steps_ff      <= steps_in;
      off_ff        <= off_in;
      clr_ff        <= clr_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   // An accepted transaction either starts the sequencer or answers at once.
   `BPA_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)
   // Every return to idle from work issues the response.
   `BPA_ASSERT_NOW(a_done_responds, clock, reset, $fell(busy), rsp_valid)
   // Failed transactions never report an address.
   `BPA_ASSERT_NOW(a_err_no_addr, clock, reset,
      rsp_valid && (rsp_status != ST_OK), rsp_block_address == '0)

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Buddy page allocator unit testbench
// Drives seed, allocation and free transactions through the command port and
// checks every response against a cycle-free model of the free lists.
// ============================================================================
module tb_top;
   import bpa_pkg::*;

   localparam int unsigned NPAGES    = 4096;
   localparam int unsigned MAX_ORD   = 10;
   localparam int unsigned PG_SHIFT  = 12;
   localparam int unsigned NIL_PAGE  = NPAGES;
   localparam int unsigned CYCLE_CAP = 4_000_000;

   typedef struct {
      logic [31:0] block_address;
      status_type  status;
   } alloc_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_command;
   logic [3:0]  req_order;
   logic [31:0] req_amount;
   logic [31:0] req_address;
   logic        rsp_valid;
   logic [31:0] rsp_block_address;
   logic [3:0]  rsp_status;
   logic        csr_write_enable;
   logic        csr_index;
   logic [19:0] csr_write_data;

   buddy_page_allocator_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_order         (req_order),
      .req_amount        (req_amount),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_block_address (rsp_block_address),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Allocator model: free lists, page bookkeeping and the latched region.
   // ---------------------------------------------------------------------
   int unsigned     free_head[0:MAX_ORD];
   int unsigned     link_next[NPAGES];
   bit [3:0]        blk_order[NPAGES];
   bit              blk_free[NPAGES];
   logic [19:0]     cfg_base_page;
   logic [12:0]     cfg_num_pages;
   longint unsigned live_base;
   int unsigned     live_pages;

   alloc_result_type pending_q[$];
   logic [31:0]     owned_blocks[$];   // addresses the model believes are allocated
   int unsigned     fail_count;
   int unsigned     cycle_count;
   bit              quiet_sender;      // suppresses random sender gaps

   function automatic bit unlink_page(int unsigned ord, int unsigned idx, bit apply);
      int unsigned prev, cur, steps;
      prev  = NIL_PAGE;
      cur   = free_head[ord];
      steps = 0;
      while (cur < NPAGES && steps < NPAGES) begin
         if (cur == idx) begin
            if (apply) begin
               if (prev == NIL_PAGE) free_head[ord] = link_next[cur];
               else link_next[prev] = link_next[cur];
               link_next[cur] = NIL_PAGE;
            end
            return 1'b1;
         end
         prev = cur;
         cur  = link_next[cur];
         steps++;
      end
      return 1'b0;
   endfunction

   function automatic void push_page(int unsigned idx, int unsigned ord);
      link_next[idx] = free_head[ord];
      free_head[ord] = idx;
   endfunction

   // Coalesces a released block with free buddies. With apply clear it only
   // checks that every buddy it would absorb is really on its list.
   function automatic bit coalesce(int unsigned blk, bit apply);
      int unsigned ord, buddy;
      ord = blk_order[blk];
      if (apply) blk_free[blk] = 1'b1;
      while (ord < MAX_ORD) begin
         buddy = blk ^ (1 << ord);
         if (buddy >= live_pages) break;
         if (!blk_free[buddy] || blk_order[buddy] != ord) break;
         if (!unlink_page(ord, buddy, apply)) return 1'b0;
         if (apply) blk_free[buddy] = 1'b0;
         if (buddy < blk) blk = buddy;
         ord++;
         if (apply) begin
            blk_order[blk] = ord[3:0];
            blk_free[blk]  = 1'b1;
         end
      end
      if (apply) push_page(blk, ord);
      return 1'b1;
   endfunction

   function automatic status_type take_block(int unsigned want, output longint unsigned addr);
      int unsigned lvl, top, half;
      addr = 0;
      if (want > MAX_ORD) return ST_BAD_ORDER;
      lvl = want;
      while (lvl <= MAX_ORD && free_head[lvl] >= NPAGES) lvl++;
      if (lvl > MAX_ORD) return ST_NO_MEMORY;
      top = free_head[lvl];
      free_head[lvl] = link_next[top];
      link_next[top] = NIL_PAGE;
      blk_free[top]  = 1'b0;
      // Split down to the wanted order, the upper halves going back free.
      while (lvl > want) begin
         lvl--;
         half = top + (1 << lvl);
         if (half < NPAGES) begin
            blk_order[half] = lvl[3:0];
            blk_free[half]  = 1'b1;
            push_page(half, lvl);
         end
      end
      blk_order[top] = want[3:0];
      addr = live_base + (longint'(top) << PG_SHIFT);
      return ST_OK;
   endfunction

   function automatic status_type take_bytes(longint unsigned size, output longint unsigned addr);
      longint unsigned span;
      int unsigned     ord;
      addr = 0;
      span = 64'd1 << PG_SHIFT;
      ord  = 0;
      if (size == 0) return ST_NULL;
      while (span < size && ord <= MAX_ORD) begin
         ord++;
         span <<= 1;
      end
      if (ord > MAX_ORD) return ST_TOO_LARGE;
      return take_block(ord, addr);
   endfunction

   function automatic status_type lay_out_region();
      longint unsigned base, stop;
      int unsigned     cnt, off, ord;
      base = longint'(cfg_base_page) << PG_SHIFT;
      stop = base + (longint'(cfg_num_pages) << PG_SHIFT);
      cnt  = cfg_num_pages;
      if (cnt == 0 || cnt > NPAGES || stop > 64'h1_0000_0000) return ST_BAD_REGION;
      for (int i = 0; i <= MAX_ORD; i++) free_head[i] = NIL_PAGE;
      for (int i = 0; i < NPAGES; i++) begin
         link_next[i] = NIL_PAGE;
         blk_order[i] = '0;
         blk_free[i]  = 1'b1;
      end
      live_base  = base;
      live_pages = cnt;
      off = 0;
      while (off < cnt) begin
         ord = 0;
         while (ord < MAX_ORD) begin
            if ((off & ((2 << ord) - 1)) != 0) break;
            if (off + (2 << ord) > cnt) break;
            ord++;
         end
         blk_order[off] = ord[3:0];
         blk_free[off]  = 1'b1;
         push_page(off, ord);
         off += 1 << ord;
      end
      return ST_OK;
   endfunction

   function automatic status_type release_block(longint unsigned a);
      int unsigned idx, ord;
      if (a == 0) return ST_NULL;
      if ((a & ((64'd1 << PG_SHIFT) - 1)) != 0) return ST_MISALIGNED;
      if (live_pages == 0 || a < live_base ||
          a >= live_base + (longint'(live_pages) << PG_SHIFT)) return ST_OUTSIDE;
      idx = 32'((a - live_base) >> PG_SHIFT);
      if (idx >= NPAGES) return ST_OUTSIDE;
      if (blk_free[idx]) return ST_DOUBLE_FREE;
      ord = blk_order[idx];
      if (ord > MAX_ORD) return ST_BAD_ORDER;
      if ((idx & ((1 << ord) - 1)) != 0) return ST_ORDER_MISAL;
      if (!coalesce(idx, 1'b0)) return ST_LIST_MISSING;
      void'(coalesce(idx, 1'b1));
      return ST_OK;
   endfunction

   function automatic alloc_result_type predict_response(logic [2:0] cmd, logic [3:0] ord,
                                                        logic [31:0] amount,
                                                        logic [31:0] addr_in);
      alloc_result_type res;
      longint unsigned  addr;
      status_type       st;
      addr = 0;
      case (cmd)
         CMD_SEED:        st = lay_out_region();
         CMD_ALLOC_ORDER: st = take_block(ord, addr);
         CMD_ALLOC_PAGES: st = (amount == 0) ? ST_NULL
                                : take_bytes(longint'(amount) << PG_SHIFT, addr);
         CMD_ALLOC_BYTES: st = take_bytes(longint'(amount), addr);
         CMD_FREE:        st = release_block(longint'(addr_in));
         default:         st = ST_NULL;
      endcase
      if (st != ST_OK) addr = 0;
      res.block_address = addr[31:0];
      res.status        = st;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Sends one transaction; start is left high so that back-to-back
   // transactions need no extra cycle.
   task automatic send_request(logic [2:0] cmd, logic [3:0] ord, logic [31:0] amount,
                               logic [31:0] addr_in);
      alloc_result_type res;
      bit               done;
      if (!quiet_sender && $urandom_range(99) < 19) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      @(negedge clock);
      start       = 1'b1;
      req_command = cmd;
      req_order   = ord;
      req_amount  = amount;
      req_address = addr_in;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         if (!busy) begin
            res = predict_response(cmd, ord, amount, addr_in);
            pending_q.push_back(res);
            if (res.status == ST_OK && (cmd == CMD_ALLOC_ORDER || cmd == CMD_ALLOC_PAGES ||
                                        cmd == CMD_ALLOC_BYTES))
               owned_blocks.push_back(res.block_address);
            if (cmd == CMD_SEED && res.status == ST_OK) owned_blocks.delete();
            done = 1'b1;
         end
      end
   endtask

   // Lowers start and waits until every response has come back.
   task automatic drain_responses();
      @(negedge clock);
      start = 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [19:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      if (idx == CSR_REGION_BASE_PAGE) cfg_base_page = data;
      else cfg_num_pages = data[12:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_region(logic [19:0] base, logic [19:0] pages_word);
      drain_responses();
      write_csr(CSR_REGION_BASE_PAGE, base);
      write_csr(CSR_REGION_PAGES, pages_word);
   endtask

   task automatic release_owned();
      int unsigned k;
      k = $urandom_range(owned_blocks.size() - 1);
      send_request(CMD_FREE, 4'($urandom), $urandom, owned_blocks[k]);
      owned_blocks.delete(k);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Nothing is seeded yet: allocations find no memory and frees fall outside.
   task automatic test_before_seed();
      send_request(CMD_ALLOC_ORDER, 4'd0, '0, '0);
      send_request(CMD_ALLOC_BYTES, 4'd0, 32'd1, '0);
      send_request(CMD_FREE, 4'd0, '0, 32'h0000_1000);
      send_request(CMD_SEED, 4'd0, '0, '0);   // no pages configured
   endtask

   // Regions that are too big or run past the 32-bit address space.
   task automatic test_region_checks();
      set_region(20'd0, 20'd4097);
      send_request(CMD_SEED, 4'd0, '0, '0);
      set_region(20'hFFFFF, 20'd2);
      send_request(CMD_SEED, 4'd0, '0, '0);
      set_region(20'hFFFFF, 20'd1);             // the very last page fits
      send_request(CMD_SEED, 4'd0, '0, '0);
      send_request(CMD_ALLOC_ORDER, 4'd0, '0, '0);
      send_request(CMD_FREE, 4'd0, '0, 32'hFFFF_F000);
   endtask

   // Every allocation flavor across the order range, plus the size limits.
   task automatic test_alloc_paths();
      set_region(20'd0, 20'hFF000 | 20'd4096);  // upper data bits are dropped
      send_request(CMD_SEED, 4'd0, '0, '0);
      for (int o = 0; o <= 15; o++) send_request(CMD_ALLOC_ORDER, 4'(o), '0, '0);
      send_request(CMD_ALLOC_PAGES, 4'd0, 32'd0, '0);
      send_request(CMD_ALLOC_BYTES, 4'd0, 32'd0, '0);
      send_request(CMD_ALLOC_PAGES, 4'd0, 32'd1024, '0);
      send_request(CMD_ALLOC_PAGES, 4'd0, 32'd1025, '0);
      send_request(CMD_ALLOC_PAGES, 4'd0, 32'hFFFF_FFFF, '0);
      send_request(CMD_ALLOC_BYTES, 4'd0, 32'hFFFF_FFFF, '0);
      send_request(CMD_ALLOC_BYTES, 4'd0, 32'd4097, '0);
   endtask

   // Free-side error checks, unknown commands, then a coalescing release.
   task automatic test_free_checks();
      logic [31:0] victim;
      victim = owned_blocks[0];
      send_request(CMD_FREE, 4'd0, '0, 32'd0);
      send_request(CMD_FREE, 4'd0, '0, victim | 32'd1);
      send_request(CMD_FREE, 4'd0, '0, 32'hFFFF_F000);
      send_request(CMD_FREE, 4'd0, '0, victim);
      send_request(CMD_FREE, 4'd0, '0, victim);                  // second release
      for (int k = 1; k <= 3; k++) send_request(3'(CMD_FREE) + 3'(k), 4'hF, '1, '1);
      owned_blocks.delete(0);
      while (owned_blocks.size() != 0) release_owned();
   endtask

   // Mostly well-formed alloc/free traffic on the current region, with noise.
   task automatic test_random_traffic(int unsigned count);
      int unsigned pick;
      logic [3:0]  ord;
      for (int n = 0; n < count; n++) begin
         quiet_sender = (n >= count / 3 && n < count / 2);
         if (n == count / 2) drain_responses();                 // sender waits out all responses
         pick = $urandom_range(99);
         ord  = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(3));
         if (pick < 20)
            send_request(CMD_ALLOC_ORDER, ord, $urandom, $urandom);
         else if (pick < 30)
            send_request(CMD_ALLOC_PAGES, 4'($urandom),
                         ($urandom_range(9) == 0) ? $urandom : $urandom_range(16), $urandom);
         else if (pick < 42)
            send_request(CMD_ALLOC_BYTES, 4'($urandom),
                         ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 65536),
                         $urandom);
         else if (pick < 85 && owned_blocks.size() != 0)
            release_owned();
         else if (pick < 99)
            send_request(3'($urandom), 4'($urandom), $urandom,
                         ($urandom_range(1) == 0) ? $urandom : ($urandom & 32'hFFFF_F000));
         else
            send_request(CMD_SEED, 4'($urandom), $urandom, $urandom);
      end
      quiet_sender = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Response checker: each strobe is matched with the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $error("response with no transaction outstanding: address %h status %0d",
                   rsp_block_address, rsp_status);
            fail_count++;
         end else begin
            exp_res = pending_q.pop_front();
            if (rsp_block_address !== exp_res.block_address) begin
               $error("block_address: expected %h, got %h", exp_res.block_address,
                      rsp_block_address);
               fail_count++;
            end
            if (rsp_status !== exp_res.status) begin
               $error("status: expected %0d, got %0d", exp_res.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Guards against a hung sequencer.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("FAIL buddy_page_allocator_unit");
         $finish;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_command      = CMD_SEED;
      req_order        = '0;
      req_amount       = '0;
      req_address      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_REGION_BASE_PAGE;
      csr_write_data   = '0;
      fail_count       = 0;
      cycle_count      = 0;
      quiet_sender     = 1'b0;
      // Model state after reset: empty lists and no latched region.
      for (int i = 0; i <= MAX_ORD; i++) free_head[i] = NIL_PAGE;
      for (int i = 0; i < NPAGES; i++) begin
         link_next[i] = 0;
         blk_order[i] = '0;
         blk_free[i]  = 1'b1;
      end
      cfg_base_page = '0;
      cfg_num_pages = '0;
      live_base     = 0;
      live_pages    = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_before_seed();
      test_region_checks();
      test_alloc_paths();
      test_free_checks();

      // Random phases over several regions, the extremes among them.
      set_region(20'd0, 20'd4096);
      send_request(CMD_SEED, 4'd0, '0, '0);
      test_random_traffic(260);
      set_region(20'hFF000, 20'd4096);
      send_request(CMD_SEED, 4'd0, '0, '0);
      test_random_traffic(220);
      set_region(20'h00123, 20'd7);
      send_request(CMD_SEED, 4'd0, '0, '0);
      test_random_traffic(180);
      set_region(20'($urandom_range(20'hFE000)), 20'($urandom_range(1, 4096)));
      send_request(CMD_SEED, 4'd0, '0, '0);
      test_random_traffic(260);
      set_region(20'hFFFFF, 20'd1);
      send_request(CMD_SEED, 4'd0, '0, '0);
      test_random_traffic(180);

      drain_responses();
      if (fail_count == 0) begin
         $display("PASS buddy_page_allocator_unit");
      end else begin
         $display("FAIL buddy_page_allocator_unit");
      end
      $finish;
   end

endmodule
